// ===== src/assert_macros.svh =====
// Assertion macros for the RTL, included by euler_to_quaternion.sv.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/e2q_pkg.sv =====
// Package for the Euler angle to quaternion converter.
// Holds angle constants, the arctangent table and default parameters.
package e2q_pkg;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int TRIG_STEPS_DEF = 16;
  localparam int TAB_LEN = 30;
  localparam int ANGLE_W = 16;
  localparam int OUT_W = 16;
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam logic signed [17:0] HALF_TURN = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN = 18'sd46080;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [18:0] RAD_PER_UNIT = 19'sd146409;
  localparam logic signed [CW-1:0] GAIN_INV = 34'sh026DD3B6A;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic [31:0] t;
    begin
      unique case (i)
        0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
        3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
        6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
        9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
        12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
        15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
        18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
        21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
        24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
        27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
        default: t = 32'h0;
      endcase
      return ZW'(signed'({1'b0, t}));
    end
  endfunction
endpackage

// ===== src/euler_to_quaternion.sv =====
// Euler angle to quaternion converter, fully pipelined.
// Depends on e2q_pkg and assert_macros.svh.
//
// Takes one angle triple per clock whenever start is high (busy is always
// low) and returns the quaternion with strobe after the wrap and radian
// stages, the CORDIC chain, one stage per iteration, and six further
// stages (sign fix, products, sums, output rounding). The result holds for
// one cycle only; the receiver cannot stall it.
`include "assert_macros.svh"
module euler_to_quaternion #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF,
  parameter int TRIG_STEPS = e2q_pkg::TRIG_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle,
  output logic strobe,
  output logic signed [e2q_pkg::OUT_W-1:0] quat_w,
  output logic signed [e2q_pkg::OUT_W-1:0] quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0] quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0] quat_z
);
  import e2q_pkg::*;

  localparam int NS = (TRIG_STEPS > TAB_LEN) ? TAB_LEN : TRIG_STEPS;
  localparam int SHIFT = 30 - OUT_FRAC_BITS;
  localparam int LAT = NS + 8;
  localparam int PW = 2 * CW;

  // Stage 0: wrap, quadrant fold. Stage 1: radian multiply.
  logic [2:0] v0, v1;
  logic signed [17:0] h0 [3];
  logic [2:0] neg0, neg1;
  logic signed [ZW-1:0] z1 [3];
  logic [LAT-1:0] vpipe;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[LAT-2:0], start};
  end

  logic signed [ANGLE_W-1:0] ang [3];
  assign ang[0] = roll_angle;
  assign ang[1] = yaw_angle;
  assign ang[2] = pitch_angle;

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic signed [17:0] w, hf;
    logic ng;
    always_comb begin
      w = 18'(ang[a]);
      if (w >= HALF_TURN) w = w - FULL_TURN;
      if (w < -HALF_TURN) w = w + FULL_TURN;
      ng = 1'b0;
      hf = w;
      if (w > QUARTER_TURN) begin
        hf = w - HALF_TURN;
        ng = 1'b1;
      end else if (w < -QUARTER_TURN) begin
        hf = w + HALF_TURN;
        ng = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      h0[a] <= hf;
      neg0[a] <= ng;
      z1[a] <= ZW'(h0[a]) * ZW'(RAD_PER_UNIT);
      neg1[a] <= neg0[a];
    end
  end

  // CORDIC chain, one iteration per stage.
  logic signed [CW-1:0] cx [3][NS+1];
  logic signed [CW-1:0] cy [3][NS+1];
  logic signed [ZW-1:0] cz [3][NS+1];
  logic [2:0] cneg [NS+1];

  for (genvar a = 0; a < 3; a++) begin : g_init
    assign cx[a][0] = GAIN_INV;
    assign cy[a][0] = '0;
    assign cz[a][0] = z1[a];
  end
  assign cneg[0] = neg1;

  for (genvar i = 0; i < NS; i++) begin : g_it
    for (genvar a = 0; a < 3; a++) begin : g_a
      always_ff @(posedge clk) begin
        if (!cz[a][i][ZW-1]) begin
          cx[a][i+1] <= cx[a][i] - (cy[a][i] >>> i);
          cy[a][i+1] <= cy[a][i] + (cx[a][i] >>> i);
          cz[a][i+1] <= cz[a][i] - atan_tab(i);
        end else begin
          cx[a][i+1] <= cx[a][i] + (cy[a][i] >>> i);
          cy[a][i+1] <= cy[a][i] - (cx[a][i] >>> i);
          cz[a][i+1] <= cz[a][i] + atan_tab(i);
        end
      end
    end
    always_ff @(posedge clk) cneg[i+1] <= cneg[i];
  end

  // Sign fix: index 0 roll, 1 yaw, 2 pitch.
  logic signed [CW-1:0] sn [3], cs [3];
  for (genvar a = 0; a < 3; a++) begin : g_fix
    always_ff @(posedge clk) begin
      sn[a] <= cneg[NS][a] ? -cy[a][NS] : cy[a][NS];
      cs[a] <= cneg[NS][a] ? -cx[a][NS] : cx[a][NS];
    end
  end

  // Pair products: cr*cp, sr*sp, sr*cp, cr*sp; yaw carried alongside.
  logic signed [PW-1:0] pp [4];
  logic signed [CW-1:0] pq [4];
  logic signed [CW-1:0] sy2, cy2, sy3, cy3;
  always_ff @(posedge clk) begin
    pp[0] <= cs[0] * cs[2];
    pp[1] <= sn[0] * sn[2];
    pp[2] <= sn[0] * cs[2];
    pp[3] <= cs[0] * sn[2];
    sy2 <= sn[1];
    cy2 <= cs[1];
    for (int k = 0; k < 4; k++) pq[k] <= CW'(pp[k] >>> 30);
    sy3 <= sy2;
    cy3 <= cy2;
  end

  // Triple products: t0=cr cp cy, t1=sr sp sy, t2=sr cp cy, t3=cr sp sy,
  // t4=cr sp cy, t5=sr cp sy, t6=cr cp sy, t7=sr sp cy.
  logic signed [PW-1:0] tp [8];
  logic signed [CW+1:0] sm [4];
  always_ff @(posedge clk) begin
    tp[0] <= pq[0] * cy3;
    tp[1] <= pq[1] * sy3;
    tp[2] <= pq[2] * cy3;
    tp[3] <= pq[3] * sy3;
    tp[4] <= pq[3] * cy3;
    tp[5] <= pq[2] * sy3;
    tp[6] <= pq[0] * sy3;
    tp[7] <= pq[1] * cy3;
    sm[0] <= (CW+2)'(tp[0] >>> 30) + (CW+2)'(tp[1] >>> 30);
    sm[1] <= (CW+2)'(tp[2] >>> 30) - (CW+2)'(tp[3] >>> 30);
    sm[2] <= (CW+2)'(tp[4] >>> 30) + (CW+2)'(tp[5] >>> 30);
    sm[3] <= (CW+2)'(tp[6] >>> 30) - (CW+2)'(tp[7] >>> 30);
  end

  localparam logic signed [CW+1:0] LIM = (CW+2)'(64'sd1 <<< OUT_FRAC_BITS);
  localparam logic signed [CW+1:0] RND =
    (SHIFT > 0) ? (CW+2)'(64'sd1 <<< (SHIFT - 1)) : '0;
  logic signed [OUT_W-1:0] qo [4];
  for (genvar k = 0; k < 4; k++) begin : g_out
    logic signed [CW+1:0] r;
    always_comb begin
      r = (sm[k] + RND) >>> SHIFT;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
    end
    always_ff @(posedge clk) qo[k] <= OUT_W'(r);
  end

  assign strobe = vpipe[LAT-1];
  assign quat_w = qo[0];
  assign quat_x = qo[1];
  assign quat_y = qo[2];
  assign quat_z = qo[3];

  `ASSERT_NEVER(a_busy_low, clk, rst, busy)
  `ASSERT_IMPL(a_strobe_lat, clk, rst, strobe |-> $past(start, LAT))
  `ASSERT_IMPL(a_w_range, clk, rst, strobe |-> (quat_w <= LIM && quat_w >= -LIM))
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for euler_to_quaternion: drives angle triples,
// predicts each quaternion with a fixed-point CORDIC model, checks every beat.
// Depends on e2q_pkg and the euler_to_quaternion RTL.
module testbench;
  import e2q_pkg::*;

  localparam int FRAC = OUT_FRAC_BITS_DEF;
  localparam int STEPS = TRIG_STEPS_DEF;
  localparam int WATCHDOG = 2000;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } quat_t;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30(int i);
    longint t[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
    return t[i];
  endfunction

  function automatic void half_sin_cos(input logic signed [15:0] raw,
                                       output longint s, output longint c);
    longint h, x, y, z, dx, dy;
    bit neg;
    int n;
    h = longint'(raw);
    neg = 0;
    x = 64'h26DD3B6A;
    y = 0;
    n = (STEPS > 30) ? 30 : STEPS;
    if (h >= 23040) h -= 46080;
    if (h < -23040) h += 46080;
    if (h > 11520) begin
      h -= 23040;
      neg = 1;
    end else if (h < -11520) begin
      h += 23040;
      neg = 1;
    end
    z = h * 146409;
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return floor_shr(floor_shr(a * b, 30) * c, 30);
  endfunction

  function automatic logic [15:0] q30_to_out(longint v);
    longint lim;
    lim = longint'(1) << FRAC;
    if (30 - FRAC > 0) v = floor_shr(v + (longint'(1) << (29 - FRAC)), 30 - FRAC);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic quat_t euler_quat(logic signed [15:0] r, logic signed [15:0] yw,
                                       logic signed [15:0] p);
    longint sr, cr, sy, cy, sp, cp;
    quat_t q;
    half_sin_cos(r, sr, cr);
    half_sin_cos(yw, sy, cy);
    half_sin_cos(p, sp, cp);
    q.w = q30_to_out(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = q30_to_out(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = q30_to_out(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = q30_to_out(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];
    int mismatches;

    function void note_angles(logic signed [15:0] r, logic signed [15:0] yw,
                              logic signed [15:0] p);
      pending.push_back(euler_quat(r, yw, p));
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch w/x/y/z: expected %h %h %h %h, got %h %h %h %h",
                   want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, strobe;
  logic signed [15:0] roll_angle, yaw_angle, pitch_angle;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  quat_scoreboard board;
  int idle_pct;
  int quiet_cycles;

  euler_to_quaternion dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    start = 0;
    roll_angle = 0;
    yaw_angle = 0;
    pitch_angle = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_angles(roll_angle, yaw_angle, pitch_angle);
      if (strobe) board.check_quat({quat_w, quat_x, quat_y, quat_z});
      if ((start && !busy) || strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 23040 : -23040);
      2: return 16'(11520 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 46080) - 23040);
    endcase
  endfunction

  task automatic send_angles(logic [15:0] r, logic [15:0] yw, logic [15:0] p);
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    roll_angle <= r;
    yaw_angle <= yw;
    pitch_angle <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [15:0] corner[12];
    corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
               16'sd11521, -16'sd11521, 16'sd23039, 16'h7FFF, 16'h8000,
               16'hFFFF, 16'sd1};
    board = new();
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 12; i++)
      send_angles(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12]);
    send_angles(16'sd5760, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sd5760, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sd5760);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 64 : (ph == 3) ? 37 : 0;
      for (int n = 0; n < 200; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    start <= 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (STEPS + 20) @(posedge clk);
    if (board.mismatches == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/e2q_pkg.sv
src/euler_to_quaternion.sv
tb/sv/testbench.sv
